@@ rtl/core/hsc_pkg.sv @@
// Shared types, constants and bit-placement functions of the Hamming SEC codec.
package hsc_pkg;

    localparam int PARITY_COUNT = 5;
    localparam int DATA_WIDTH   = 15;
    localparam int CODE_WIDTH   = 20;

    typedef logic [DATA_WIDTH-1:0]   data_t;
    typedef logic [CODE_WIDTH-1:0]   code_t;
    typedef logic [PARITY_COUNT-1:0] syn_t;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    typedef struct packed {
        op_t   operation;
        data_t data_word;
        code_t code_word;
    } cmd_t;

    typedef struct packed {
        code_t code_out;
        data_t data_out;
        syn_t  syndrome;
        logic  corrected;
        logic  uncorrectable;
    } res_t;

    // True for the position numbers that hold parity bits.
    function automatic logic is_pow2(input int n);
        return (n != 0) && ((n & (n - 1)) == 0);
    endfunction

    // Positions, as a bit mask over the code word, covered by parity check p.
    function automatic code_t cover_mask(input int p);
        code_t m;
        m = '0;
        for (int j = 0; j < CODE_WIDTH; j++) begin
            m[j] = (((j + 1) >> p) & 1) != 0;
        end
        return m;
    endfunction

    // Spreads the data bits over the non-parity positions, parity positions left clear.
    function automatic code_t place_data(input data_t d);
        code_t w;
        int    k;
        w = '0;
        k = 0;
        for (int j = 0; j < CODE_WIDTH; j++) begin
            if (!is_pow2(j + 1) && (k < DATA_WIDTH)) begin
                w[j] = d[k];
                k++;
            end
        end
        return w;
    endfunction

    // Gathers the data bits back out of the non-parity positions.
    function automatic data_t extract_data(input code_t w);
        data_t d;
        int    k;
        d = '0;
        k = 0;
        for (int j = 0; j < CODE_WIDTH; j++) begin
            if (!is_pow2(j + 1) && (k < DATA_WIDTH)) begin
                d[k] = w[j];
                k++;
            end
        end
        return d;
    endfunction

endpackage

@@ rtl/core/hamming_sec_codec.sv @@
// Top level of the shortened Hamming single-error-correcting codec.
//
// The codec takes one transaction per clock on the cmd channel while cmd_ready is high
// and returns one result transaction per command on the res channel, in order. A
// command is captured in an input register; the XOR trees for encoding, the syndrome,
// the single-bit flip and the data extraction sit between that register and the result
// register, which offers the result to the res channel. While res_ready stays high the
// sustained rate is one transaction per cycle. The input register keeps taking commands
// while a finished result waits on res_ready, so a stall on the result
// side reaches cmd_ready only once both registers are full. In encode mode the data bits
// are placed at the positions that are not powers of two and each parity bit is the even
// parity of the positions it covers; the data, syndrome and flag fields of the result are
// zero. In decode mode the syndrome names the failing position, which is flipped and
// reported through corrected. A syndrome that points beyond the twenty code positions
// leaves the word untouched and raises uncorrectable instead; data is then taken from the
// received word.
module hamming_sec_codec (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  hsc_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output hsc_pkg::res_t res
);

    logic          stage_valid_reg;
    logic          stage_valid_next;
    hsc_pkg::cmd_t stage_reg;
    logic          res_valid_reg;
    logic          res_valid_next;
    hsc_pkg::res_t res_reg;
    hsc_pkg::res_t res_next;
    logic          advance;

    hsc_pkg::code_t placed;
    hsc_pkg::code_t enc_word;
    hsc_pkg::code_t fixed_word;
    hsc_pkg::code_t flip_mask;
    hsc_pkg::syn_t  syn;
    logic           syn_in_range;

    // The result register moves whenever it is empty or its content is being taken.
    assign advance   = !res_valid_reg || res_ready;
    assign cmd_ready = !stage_valid_reg || advance;

    always_comb
    begin
        stage_valid_next = cmd_ready ? cmd_valid : stage_valid_reg;
        res_valid_next   = advance ? stage_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready)
        begin
            stage_reg <= cmd;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // Encoding: parity positions are clear in the placed word, so each parity bit is
    // simply the XOR of everything its check covers.
    always_comb
    begin
        placed   = hsc_pkg::place_data(stage_reg.data_word);
        enc_word = placed;
        for (int p = 0; p < hsc_pkg::PARITY_COUNT; p++)
        begin
            if (((1 << p) - 1) < hsc_pkg::CODE_WIDTH)
            begin
                enc_word[(1 << p) - 1] = ^(placed & hsc_pkg::cover_mask(p));
            end
        end
    end

    // Decoding: each failing check contributes its own position bit to the syndrome.
    always_comb
    begin
        syn = '0;
        for (int p = 0; p < hsc_pkg::PARITY_COUNT; p++)
        begin
            if (((1 << p) - 1) < hsc_pkg::CODE_WIDTH)
            begin
                syn[p] = ^(stage_reg.code_word & hsc_pkg::cover_mask(p));
            end
        end
        syn_in_range = (int'(syn) <= hsc_pkg::CODE_WIDTH);
        for (int j = 0; j < hsc_pkg::CODE_WIDTH; j++)
        begin
            flip_mask[j] = (int'(syn) == (j + 1));
        end
        fixed_word = stage_reg.code_word ^ flip_mask;
    end

    always_comb
    begin
        res_next = '0;
        case (stage_reg.operation)
            hsc_pkg::OP_ENCODE:
            begin
                res_next.code_out = enc_word;
            end
            hsc_pkg::OP_DECODE:
            begin
                res_next.code_out      = fixed_word;
                res_next.data_out      = hsc_pkg::extract_data(fixed_word);
                res_next.syndrome      = syn;
                res_next.corrected     = (syn != '0) && syn_in_range;
                res_next.uncorrectable = !syn_in_range;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef ASSERT_OFF
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.corrected && res_reg.uncorrectable))
        else $error("corrected and uncorrectable raised together");

    a_corrected_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.corrected) |->
            (res_reg.syndrome != '0) && (int'(res_reg.syndrome) <= hsc_pkg::CODE_WIDTH))
        else $error("correction reported for a syndrome outside the code");

    a_uncorr_syndrome: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.uncorrectable) |->
            (int'(res_reg.syndrome) > hsc_pkg::CODE_WIDTH))
        else $error("uncorrectable flag with an in-range syndrome");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=> (stage_valid_reg && $stable(stage_reg)))
        else $error("held command lost while the result register was stalled");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && advance) |=> res_valid_reg)
        else $error("command left the input register without producing a result");
`endif

endmodule

@@ tb/hamming_sec_codec_tb.sv @@
// Self-checking testbench of the Hamming SEC codec: encode and decode with injected bit errors.
module hamming_sec_codec_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Number of random transactions that follow the directed ones.
    localparam int RANDOM_ITEMS = 950;
    // Cycles with no transaction on either channel before the run is abandoned. The longest
    // legitimate quiet spell is a receiver hold-off plus a short sender gap.
    localparam int IDLE_LIMIT   = 2000;
    // Length of the long receiver hold-off, and how many results apart two of them start.
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_EVERY   = 400;
    // Edges waited after the last result, in which anything spurious would be caught.
    localparam int TAIL_CYCLES  = 8;

    // Receiver behaviour, chosen in turn from rx_cycle so that stalls fall on every phase.
    typedef enum logic [1:0] {
        RX_FREE,    // ready throughout
        RX_COIN,    // ready half of the time at random
        RX_SPARSE,  // ready when rx_cycle is a multiple of four
        RX_BUSY     // ready at random with a probability of nine in ten
    } rx_mode_t;

    logic           clk;
    logic           rst_n     = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_ready;
    hsc_pkg::cmd_t  cmd       = '0;
    logic           res_valid;
    logic           res_ready = 1'b0;
    hsc_pkg::res_t  res;

    // Commands still to be offered, and the results predicted for accepted commands.
    hsc_pkg::cmd_t  pending_cmds[$];
    hsc_pkg::res_t  predicted_res[$];

    int             mismatches    = 0;
    int             burst_left    = 0;
    int             gap_left      = 0;
    int             rx_cycle      = 0;
    int             hold_left     = 0;
    int             results_taken = 0;
    int             next_hold_at  = 300;
    int             idle_cycles   = 0;
    hsc_pkg::res_t  want_res;

    hamming_sec_codec i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Even parity of every position covered by check p, the check's own position excluded.
    // Positions are numbered from one, position n sitting in bit n-1 of the word.
    function automatic logic covered_parity(input hsc_pkg::code_t w, input int p);
        logic acc;
        acc = 1'b0;
        for (int pos = 1; pos <= hsc_pkg::CODE_WIDTH; pos++)
        begin
            if (pos != (1 << p) && ((pos >> p) & 1) != 0)
                acc ^= w[pos-1];
        end
        return acc;
    endfunction

    // Builds the code word: data bits in ascending order at the positions that are not
    // powers of two, then each parity bit set so that its check comes out even.
    function automatic hsc_pkg::code_t hamming_encode(input hsc_pkg::data_t d);
        hsc_pkg::code_t w;
        int             k;
        w = '0;
        k = 0;
        for (int pos = 1; pos <= hsc_pkg::CODE_WIDTH; pos++)
        begin
            if ((pos & (pos - 1)) != 0 && k < hsc_pkg::DATA_WIDTH)
            begin
                w[pos-1] = d[k];
                k++;
            end
        end
        for (int p = 0; p < hsc_pkg::PARITY_COUNT; p++)
        begin
            if ((1 << p) <= hsc_pkg::CODE_WIDTH)
                w[(1 << p) - 1] = covered_parity(w, p);
        end
        return w;
    endfunction

    // Expected result of one command. In encode mode only code_out carries anything. In
    // decode mode the failing checks add up to the syndrome; a syndrome inside the word is
    // corrected by a single flip, one beyond the twenty positions is only flagged.
    function automatic hsc_pkg::res_t predict_codec_result(input hsc_pkg::cmd_t c);
        hsc_pkg::res_t  r;
        hsc_pkg::code_t w;
        int             syn;
        int             k;
        r = '0;
        if (c.operation == hsc_pkg::OP_ENCODE)
        begin
            r.code_out = hamming_encode(c.data_word);
            return r;
        end
        w   = c.code_word;
        syn = 0;
        for (int p = 0; p < hsc_pkg::PARITY_COUNT; p++)
        begin
            if ((1 << p) <= hsc_pkg::CODE_WIDTH && w[(1 << p) - 1] != covered_parity(w, p))
                syn += 1 << p;
        end
        if (syn != 0)
        begin
            if (syn <= hsc_pkg::CODE_WIDTH)
            begin
                w[syn-1]    = ~w[syn-1];
                r.corrected = 1'b1;
            end
            else
            begin
                r.uncorrectable = 1'b1;
            end
        end
        k = 0;
        for (int pos = 1; pos <= hsc_pkg::CODE_WIDTH; pos++)
        begin
            if ((pos & (pos - 1)) != 0 && k < hsc_pkg::DATA_WIDTH)
            begin
                r.data_out[k] = w[pos-1];
                k++;
            end
        end
        r.code_out = w;
        r.syndrome = hsc_pkg::syn_t'(syn);
        return r;
    endfunction

    // The field that the chosen operation ignores is filled at random, so that it is seen
    // to have no effect.
    function automatic hsc_pkg::cmd_t encode_cmd(input hsc_pkg::data_t d);
        hsc_pkg::cmd_t c;
        c.operation = hsc_pkg::OP_ENCODE;
        c.data_word = d;
        c.code_word = hsc_pkg::code_t'($urandom);
        return c;
    endfunction

    function automatic hsc_pkg::cmd_t decode_cmd(input hsc_pkg::code_t w);
        hsc_pkg::cmd_t c;
        c.operation = hsc_pkg::OP_DECODE;
        c.data_word = hsc_pkg::data_t'($urandom);
        c.code_word = w;
        return c;
    endfunction

    function automatic hsc_pkg::code_t position_bit(input int pos);
        return hsc_pkg::code_t'(1) << (pos - 1);
    endfunction

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Sender. A new command is presented only once the previous transaction has completed,
    // so valid and the payload hold steady while the codec stalls. Commands go out in bursts
    // of random length; after a burst the sender usually pauses for a random gap, and now
    // and then carries straight on, giving long unbroken stretches. The prediction is made
    // at the edge that accepts the command, from the payload still on the port.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
        end
        else if (!cmd_valid || cmd_ready)
        begin
            if (cmd_valid)
                predicted_res.push_back(predict_codec_result(cmd));
            if (gap_left > 0)
            begin
                gap_left--;
                cmd_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 48);
                cmd       <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // Receiver. Its ready follows a pattern that cycles through the modes above. Once 300
    // results have been taken, and every HOLD_EVERY results after that, it holds off
    // completely for the spell set by HOLD_CYCLES while the sender keeps offering commands,
    // so that both of the codec's registers fill and cmd_ready falls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (res_valid && res_ready)
                results_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (results_taken >= next_hold_at)
            begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + HOLD_EVERY;
                res_ready   <= 1'b0;
            end
            else
            begin
                case (rx_mode_t'((rx_cycle / 64) % 4))
                    RX_FREE:   res_ready <= 1'b1;
                    RX_COIN:   res_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: res_ready <= (rx_cycle % 4) == 0;
                    default:   res_ready <= $urandom_range(0, 9) != 0;
                endcase
            end
        end
    end

    // Checker. Each result transaction is compared field by field with the oldest
    // prediction; a result that arrives with nothing predicted is an error in itself.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (predicted_res.size() == 0)
            begin
                $display("%0t: result with no command outstanding, expected none, actual %p",
                         $time, res);
                mismatches++;
            end
            else
            begin
                want_res = predicted_res.pop_front();
                check_field("code_out", 32'(res.code_out), 32'(want_res.code_out));
                check_field("data_out", 32'(res.data_out), 32'(want_res.data_out));
                check_field("syndrome", 32'(res.syndrome), 32'(want_res.syndrome));
                check_field("corrected", 32'(res.corrected), 32'(want_res.corrected));
                check_field("uncorrectable", 32'(res.uncorrectable),
                            32'(want_res.uncorrectable));
            end
        end
    end

    // Watchdog. A run in which no transaction completes on either channel until idle_cycles
    // reaches IDLE_LIMIT has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, predicted_res.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int             single_pos[7] = '{1, 2, 3, 8, 16, 17, 20};
        hsc_pkg::code_t base;
        hsc_pkg::code_t w;
        hsc_pkg::data_t d;
        int             kind;
        int             pa;
        int             pb;

        // Directed part: data extremes and alternating patterns through the encoder, clean
        // words, an all-ones word, single errors on parity and data positions at both ends
        // of the word, patterns with a syndrome beyond position twenty, and a miscorrected pair.
        pending_cmds.push_back(encode_cmd('0));
        pending_cmds.push_back(encode_cmd('1));
        pending_cmds.push_back(encode_cmd(15'h5555));
        pending_cmds.push_back(encode_cmd(15'h2AAA));
        pending_cmds.push_back(decode_cmd('0));
        pending_cmds.push_back(decode_cmd(hamming_encode('1)));
        pending_cmds.push_back(decode_cmd('1));
        base = hamming_encode(15'h1234);
        foreach (single_pos[i])
            pending_cmds.push_back(decode_cmd(base ^ position_bit(single_pos[i])));
        // Parity positions 1, 4 and 16 flipped give syndrome 21, just past the word.
        pending_cmds.push_back(decode_cmd(base ^ 20'h08009));
        // All five parity positions flipped give the largest syndrome, 31.
        pending_cmds.push_back(decode_cmd(base ^ 20'h0808B));
        // Positions 8 and 16 flipped give syndrome 24.
        pending_cmds.push_back(decode_cmd(base ^ 20'h08080));
        // Data positions 12 and 19 flipped give syndrome 31 as well.
        pending_cmds.push_back(decode_cmd(base ^ 20'h40800));
        // Positions 3 and 5 flipped point at position 6, which is wrongly corrected.
        pending_cmds.push_back(decode_cmd(base ^ 20'h00014));

        // Random part: mostly genuine code words carrying no, one or two errors, the rest
        // encodes and arbitrary received words.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = $urandom_range(0, 99);
            d    = hsc_pkg::data_t'($urandom);
            w    = hamming_encode(d);
            pa   = $urandom_range(1, hsc_pkg::CODE_WIDTH);
            pb   = $urandom_range(1, hsc_pkg::CODE_WIDTH - 1);
            if (pb >= pa)
                pb++;
            if (kind < 35)
                pending_cmds.push_back(encode_cmd(d));
            else if (kind < 50)
                pending_cmds.push_back(decode_cmd(w));
            else if (kind < 80)
                pending_cmds.push_back(decode_cmd(w ^ position_bit(pa)));
            else if (kind < 90)
                pending_cmds.push_back(decode_cmd(w ^ position_bit(pa) ^ position_bit(pb)));
            else
                pending_cmds.push_back(decode_cmd(hsc_pkg::code_t'($urandom)));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every command to be accepted and every predicted result to arrive, then
        // wait out the tail in which a stray result would show up.
        while (pending_cmds.size() != 0 || cmd_valid || predicted_res.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ hamming_sec_codec.f @@
rtl/core/hsc_pkg.sv
rtl/core/hamming_sec_codec.sv
tb/hamming_sec_codec_tb.sv
